// File: rtl/assert_macros.svh
// Assertion helpers; clocked on clk_i, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DJC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define DJC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define DJC_ASSERT(lbl, prop)
`define DJC_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

// File: rtl/djc_pkg.sv
package djc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int DW        = IN_W + 1;
  localparam int NW        = 2 * DW;
  localparam int RW        = DW;
  localparam int SQ_STEPS  = NW / 2;
  localparam int SRW       = RW + 4;
  localparam int QB        = 35;
  localparam int GW        = FRAC_BITS + 2;
  localparam int LEN_W     = 31;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic [SRW-1:0] rem;
    logic [RW-1:0]  root;
    logic [NW-1:0]  rad;
  } sqrt_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] nq;
    logic [RW-1:0] dvs;
  } div_t;

endpackage

// File: rtl/djc_sqrt_cell.sv
module djc_sqrt_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  djc_pkg::sqrt_t cell_i,
  output djc_pkg::sqrt_t cell_o
);
  import djc_pkg::*;

  logic [SRW-1:0] shifted;
  logic [SRW-1:0] trial;
  sqrt_t          cell_d;
  sqrt_t          cell_q;

  always_comb begin
    shifted    = {cell_i.rem[SRW-3:0], cell_i.rad[NW-1 -: 2]};
    trial      = {{(SRW-RW-2){1'b0}}, cell_i.root, 2'b01};
    cell_d.rad = {cell_i.rad[NW-3:0], 2'b00};
    if (shifted >= trial) begin
      cell_d.rem  = shifted - trial;
      cell_d.root = {cell_i.root[RW-2:0], 1'b1};
    end else begin
      cell_d.rem  = shifted;
      cell_d.root = {cell_i.root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/djc_div_cell.sv
module djc_div_cell (
  input  logic         clk_i,
  input  logic         en_i,
  input  djc_pkg::div_t cell_i,
  output djc_pkg::div_t cell_o
);
  import djc_pkg::*;

  logic [RW:0] trial;
  logic        qbit;
  div_t        cell_d;
  div_t        cell_q;

  always_comb begin
    trial      = {cell_i.rem, cell_i.nq[QB-1]};
    cell_d.dvs = cell_i.dvs;
    if (trial >= {1'b0, cell_i.dvs}) begin
      qbit       = 1'b1;
      cell_d.rem = RW'(trial - {1'b0, cell_i.dvs});
    end else begin
      qbit       = 1'b0;
      cell_d.rem = trial[RW-1:0];
    end
    cell_d.nq = {cell_i.nq[QB-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/distance_constraint_jacobian.sv
// Rod distance constraint evaluator: for two particles it returns C = |d| - L, its rate, the
// first particle's Jacobian row d/|d| (signed Q2.16) and that row's time derivative, the rest
// signed Q16.16 and saturated, with a degenerate flag when the particles coincide. The block
// accepts one transaction every cycle while not stalled, returning one result for each, in
// order. The pipeline holds the 33-cell square root chain and the two 35-cell divider chains
// (one quotient bit per cell), plus the difference, product and setup stages and the output
// register. A stalled output freezes the pipeline only once its last stage is full.
`include "assert_macros.svh"
module distance_constraint_jacobian (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [djc_pkg::IN_W-1:0]      pos_a_x_i,
  input  logic signed [djc_pkg::IN_W-1:0]      pos_a_y_i,
  input  logic signed [djc_pkg::IN_W-1:0]      pos_b_x_i,
  input  logic signed [djc_pkg::IN_W-1:0]      pos_b_y_i,
  input  logic signed [djc_pkg::IN_W-1:0]      vel_a_x_i,
  input  logic signed [djc_pkg::IN_W-1:0]      vel_a_y_i,
  input  logic signed [djc_pkg::IN_W-1:0]      vel_b_x_i,
  input  logic signed [djc_pkg::IN_W-1:0]      vel_b_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [djc_pkg::IN_W-1:0]      violation_o,
  output logic signed [djc_pkg::IN_W-1:0]      violation_rate_o,
  output logic signed [djc_pkg::GW-1:0]        grad_x_o,
  output logic signed [djc_pkg::GW-1:0]        grad_y_o,
  output logic signed [djc_pkg::IN_W-1:0]      grad_rate_x_o,
  output logic signed [djc_pkg::IN_W-1:0]      grad_rate_y_o,
  output logic                                 degenerate_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [djc_pkg::LEN_W-1:0]            cfg_data_i
);
  import djc_pkg::*;

  localparam int LN_RATE = 0;
  localparam int LN_GX   = 1;
  localparam int LN_GY   = 2;
  localparam int LN_T    = 3;
  localparam int LANES1  = 4;
  localparam int LN_JX   = 0;
  localparam int LN_JY   = 1;
  localparam int LANES2  = 2;
  localparam int NST     = 6 + SQ_STEPS + 2 * QB;

  localparam logic [QB-1:0] QPOS_LIM = QB'((64'd1 << (IN_W - 1)) - 1);
  localparam logic [QB-1:0] QNEG_LIM = QB'(64'd1 << (IN_W - 1));
  localparam logic signed [RW+1:0] VMAX = (RW+2)'((64'd1 << (IN_W - 1)) - 1);
  localparam logic signed [IN_W-1:0] OMAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] OMIN = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [GW-1:0] GMAX = GW'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dvx;
    logic signed [DW-1:0] dvy;
  } a_t;

  typedef struct packed {
    logic signed [NW-1:0] pxx;
    logic signed [NW-1:0] pyy;
    logic signed [NW-1:0] pr1;
    logic signed [NW-1:0] pr2;
    logic signed [NW-1:0] pc1;
    logic signed [NW-1:0] pc2;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } b_t;

  typedef struct packed {
    logic [NW-1:0] rmag;
    logic          rneg;
    logic [NW-1:0] cmag;
    logic          cneg;
    logic [DW-1:0] xmag;
    logic          xneg;
    logic [DW-1:0] ymag;
    logic          yneg;
  } sq_side_t;

  typedef struct packed {
    logic            deg;
    logic            rovf;
    logic            rneg;
    logic            xneg;
    logic            yneg;
    logic            tneg;
    logic [IN_W-1:0] viol;
    logic            vsat;
  } d1_side_t;

  typedef struct packed {
    logic            deg;
    logic            jxneg;
    logic            jyneg;
    logic            jxovf;
    logic            jyovf;
    logic [IN_W-1:0] viol;
    logic [IN_W-1:0] rate;
    logic [GW-1:0]   gx;
    logic [GW-1:0]   gy;
    logic            sat;
  } d2_side_t;

  typedef struct packed {
    logic [NW-1:0] jxmag;
    logic [NW-1:0] jymag;
    logic [RW-1:0] dvs;
  } e_t;

  typedef struct packed {
    logic [IN_W-1:0] val;
    logic            sat;
  } sat_t;

  function automatic div_t div_init(input logic [NW-1:0] num, input logic [RW-1:0] dvs);
    div_t v;
    v.rem = RW'(num[NW-1:QB]);
    v.nq  = num[QB-1:0];
    v.dvs = dvs;
    return v;
  endfunction

  function automatic logic div_ovf(input logic [NW-1:0] num, input logic [RW-1:0] dvs);
    return RW'(num[NW-1:QB]) >= dvs;
  endfunction

  function automatic sat_t sat_mag(input logic [QB-1:0] q, input logic ovf, input logic neg);
    sat_t s;
    if (neg) begin
      if (ovf || q > QNEG_LIM) begin
        s.val = OMIN;
        s.sat = 1'b1;
      end else begin
        s.val = IN_W'(~q + QB'(1));
        s.sat = 1'b0;
      end
    end else begin
      if (ovf || q > QPOS_LIM) begin
        s.val = OMAX;
        s.sat = 1'b1;
      end else begin
        s.val = IN_W'(q);
        s.sat = 1'b0;
      end
    end
    return s;
  endfunction

  logic             en;
  logic             ld;
  logic             in_acc;
  logic [NST-1:0]   vld_q;
  logic [LEN_W-1:0] rod_length_q;

  a_t       a_q;
  b_t       b_q;
  sqrt_t    c_sq_q;
  sq_side_t c_side_q;
  sqrt_t    sq [SQ_STEPS+1];
  sq_side_t sds_q [SQ_STEPS];
  div_t     d_lane_q [LANES1];
  d1_side_t d_side_q;
  div_t     dv1 [LANES1][QB+1];
  d1_side_t d1s_q [QB];
  e_t       e_q;
  d2_side_t e_side_q;
  div_t     f_lane_q [LANES2];
  d2_side_t f_side_d;
  d2_side_t f_side_q;
  div_t     dv2 [LANES2][QB+1];
  d2_side_t d2s_q [QB];

  logic signed [NW:0]   rsum;
  logic signed [NW:0]   csum;
  logic [NW-1:0]        nsum;
  logic [RW-1:0]        root;
  logic signed [RW+1:0] vdiff;
  sq_side_t             sq_end;
  d1_side_t             d1_end;
  d2_side_t             d2_end;
  sat_t                 rate_s;
  sat_t                 jx_s;
  sat_t                 jy_s;
  logic [GW-1:0]        gxmag;
  logic [GW-1:0]        gymag;

  logic                   out_vld_q;
  logic signed [IN_W-1:0] viol_q;
  logic signed [IN_W-1:0] rate_q;
  logic signed [GW-1:0]   gx_q;
  logic signed [GW-1:0]   gy_q;
  logic signed [IN_W-1:0] jx_q;
  logic signed [IN_W-1:0] jy_q;
  logic                   deg_q;
  logic                   sat_q;
  logic                   sat_bound;

  assign ld         = !out_vld_q || !out_stall_i;
  assign en         = ld || !vld_q[NST-1];
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rod_length_q <= LEN_RESET;
    end else if (cfg_valid_i) begin
      rod_length_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_acc};
    end
  end

  // differences, products, sums
  always_comb begin
    rsum = (NW+1)'(b_q.pr1) + (NW+1)'(b_q.pr2);
    csum = (NW+1)'(b_q.pc1) - (NW+1)'(b_q.pc2);
    nsum = $unsigned(b_q.pxx) + $unsigned(b_q.pyy);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q.dx  <= {pos_a_x_i[IN_W-1], pos_a_x_i} - {pos_b_x_i[IN_W-1], pos_b_x_i};
      a_q.dy  <= {pos_a_y_i[IN_W-1], pos_a_y_i} - {pos_b_y_i[IN_W-1], pos_b_y_i};
      a_q.dvx <= {vel_a_x_i[IN_W-1], vel_a_x_i} - {vel_b_x_i[IN_W-1], vel_b_x_i};
      a_q.dvy <= {vel_a_y_i[IN_W-1], vel_a_y_i} - {vel_b_y_i[IN_W-1], vel_b_y_i};

      b_q.pxx <= NW'(a_q.dx) * NW'(a_q.dx);
      b_q.pyy <= NW'(a_q.dy) * NW'(a_q.dy);
      b_q.pr1 <= NW'(a_q.dx) * NW'(a_q.dvx);
      b_q.pr2 <= NW'(a_q.dy) * NW'(a_q.dvy);
      b_q.pc1 <= NW'(a_q.dvx) * NW'(a_q.dy);
      b_q.pc2 <= NW'(a_q.dx) * NW'(a_q.dvy);
      b_q.dx  <= a_q.dx;
      b_q.dy  <= a_q.dy;

      c_sq_q.rem    <= '0;
      c_sq_q.root   <= '0;
      c_sq_q.rad    <= nsum;
      c_side_q.rneg <= rsum[NW];
      c_side_q.rmag <= rsum[NW] ? NW'(-rsum) : NW'(rsum);
      c_side_q.cneg <= csum[NW];
      c_side_q.cmag <= csum[NW] ? NW'(-csum) : NW'(csum);
      c_side_q.xneg <= b_q.dx[DW-1];
      c_side_q.xmag <= b_q.dx[DW-1] ? DW'(-b_q.dx) : DW'(b_q.dx);
      c_side_q.yneg <= b_q.dy[DW-1];
      c_side_q.ymag <= b_q.dy[DW-1] ? DW'(-b_q.dy) : DW'(b_q.dy);
    end
  end

  // square root chain
  assign sq[0] = c_sq_q;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    djc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (sq[k]),
      .cell_o (sq[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sds_q[0] <= c_side_q;
      for (int k = 1; k < SQ_STEPS; k++) begin
        sds_q[k] <= sds_q[k-1];
      end
    end
  end

  // first divider setup
  assign root   = sq[SQ_STEPS].root;
  assign sq_end = sds_q[SQ_STEPS-1];
  assign vdiff  = $signed({2'b00, root}) - $signed((RW+2)'(rod_length_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_lane_q[LN_RATE] <= div_init(sq_end.rmag, root);
      d_lane_q[LN_GX]   <= div_init(NW'(sq_end.xmag) << FRAC_BITS, root);
      d_lane_q[LN_GY]   <= div_init(NW'(sq_end.ymag) << FRAC_BITS, root);
      d_lane_q[LN_T]    <= div_init(sq_end.cmag, root);
      d_side_q.deg      <= (root == '0);
      d_side_q.rovf     <= div_ovf(sq_end.rmag, root);
      d_side_q.rneg     <= sq_end.rneg;
      d_side_q.xneg     <= sq_end.xneg;
      d_side_q.yneg     <= sq_end.yneg;
      d_side_q.tneg     <= sq_end.cneg;
      d_side_q.vsat     <= (vdiff > VMAX);
      d_side_q.viol     <= (vdiff > VMAX) ? OMAX : vdiff[IN_W-1:0];
    end
  end

  for (genvar l = 0; l < LANES1; l++) begin : g_lane1
    assign dv1[l][0] = d_lane_q[l];
    for (genvar k = 0; k < QB; k++) begin : g_step
      djc_div_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .cell_i (dv1[l][k]),
        .cell_o (dv1[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1s_q[0] <= d_side_q;
      for (int k = 1; k < QB; k++) begin
        d1s_q[k] <= d1s_q[k-1];
      end
    end
  end

  // rows, rate, and the products for the row derivative
  assign d1_end = d1s_q[QB-1];
  assign rate_s = sat_mag(dv1[LN_RATE][QB].nq, d1_end.rovf, d1_end.rneg);
  assign gxmag  = dv1[LN_GX][QB].nq[GW-1:0];
  assign gymag  = dv1[LN_GY][QB].nq[GW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q.jxmag      <= NW'(gymag[FRAC_BITS:0]) * NW'(dv1[LN_T][QB].nq);
      e_q.jymag      <= NW'(gxmag[FRAC_BITS:0]) * NW'(dv1[LN_T][QB].nq);
      e_q.dvs        <= dv1[LN_RATE][QB].dvs;
      e_side_q.deg   <= d1_end.deg;
      e_side_q.jxneg <= d1_end.yneg ^ d1_end.tneg;
      e_side_q.jyneg <= ~(d1_end.xneg ^ d1_end.tneg);
      e_side_q.jxovf <= 1'b0;
      e_side_q.jyovf <= 1'b0;
      e_side_q.viol  <= d1_end.viol;
      e_side_q.rate  <= rate_s.val;
      e_side_q.gx    <= d1_end.xneg ? (~gxmag + GW'(1)) : gxmag;
      e_side_q.gy    <= d1_end.yneg ? (~gymag + GW'(1)) : gymag;
      e_side_q.sat   <= d1_end.vsat | rate_s.sat;
    end
  end

  // second divider setup
  always_comb begin
    f_side_d       = e_side_q;
    f_side_d.jxovf = div_ovf(e_q.jxmag, e_q.dvs);
    f_side_d.jyovf = div_ovf(e_q.jymag, e_q.dvs);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_lane_q[LN_JX] <= div_init(e_q.jxmag, e_q.dvs);
      f_lane_q[LN_JY] <= div_init(e_q.jymag, e_q.dvs);
      f_side_q        <= f_side_d;
    end
  end

  for (genvar l = 0; l < LANES2; l++) begin : g_lane2
    assign dv2[l][0] = f_lane_q[l];
    for (genvar k = 0; k < QB; k++) begin : g_step
      djc_div_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .cell_i (dv2[l][k]),
        .cell_o (dv2[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2s_q[0] <= f_side_q;
      for (int k = 1; k < QB; k++) begin
        d2s_q[k] <= d2s_q[k-1];
      end
    end
  end

  // output register
  assign d2_end = d2s_q[QB-1];
  assign jx_s   = sat_mag(dv2[LN_JX][QB].nq, d2_end.jxovf, d2_end.jxneg);
  assign jy_s   = sat_mag(dv2[LN_JY][QB].nq, d2_end.jyovf, d2_end.jyneg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ld) begin
      out_vld_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      deg_q <= d2_end.deg;
      if (d2_end.deg) begin
        viol_q <= '0;
        rate_q <= '0;
        gx_q   <= '0;
        gy_q   <= '0;
        jx_q   <= '0;
        jy_q   <= '0;
        sat_q  <= 1'b0;
      end else begin
        viol_q <= d2_end.viol;
        rate_q <= d2_end.rate;
        gx_q   <= d2_end.gx;
        gy_q   <= d2_end.gy;
        jx_q   <= jx_s.val;
        jy_q   <= jy_s.val;
        sat_q  <= d2_end.sat | jx_s.sat | jy_s.sat;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign violation_o      = viol_q;
  assign violation_rate_o = rate_q;
  assign grad_x_o         = gx_q;
  assign grad_y_o         = gy_q;
  assign grad_rate_x_o    = jx_q;
  assign grad_rate_y_o    = jy_q;
  assign degenerate_o     = deg_q;
  assign saturated_o      = sat_q;

  assign sat_bound = (viol_q == OMAX) || (rate_q == OMAX) || (rate_q == OMIN) ||
                     (jx_q == OMAX) || (jx_q == OMIN) || (jy_q == OMAX) || (jy_q == OMIN);

  `DJC_ASSERT(a_deg_zero, out_valid_o && degenerate_o |-> viol_q == '0 && jx_q == '0 && !sat_q)
  `DJC_ASSERT(a_grad_range, out_valid_o |-> gx_q <= GMAX && gx_q >= -GMAX && gy_q <= GMAX)
  `DJC_ASSERT_MSG(a_sat_bound, out_valid_o && saturated_o |-> sat_bound, "clamp flag off bound")
  `DJC_ASSERT_MSG(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "spurious stall")

endmodule
